FILE: sv/fph_pkg.sv
// Shared types and constants for the fit-policy hole allocator.
// No dependencies; used by the top level, the checker and the testbench.
package fph_pkg;

  // Fixed field widths of the item and result beats
  localparam int FIELD_W   = 16;
  localparam int SLOT_W    = 4;
  localparam int OPCODE_W  = 1;
  localparam int STATUS_W  = 2;
  localparam int POLICY_W  = 2;
  localparam int HOLES_W   = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Parameter defaults
  localparam int MAX_HOLES_DEF = 16;
  localparam int ADDR_BITS_DEF = 16;

  localparam logic [HOLES_W-1:0] HOLES_IN_USE_RST = HOLES_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY       = 2'd0,
    REG_HOLES_IN_USE = 2'd1
  } cfg_reg_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED   = 2'd0,
    ST_ALLOC    = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_BAD_LOAD = 2'd3
  } status_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST  = 2'd0,
    POL_BEST   = 2'd1,
    POL_WORST  = 2'd2,
    POL_UNUSED = 2'd3
  } policy_t;

endpackage

FILE: sv/fph_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced for the hole table.
module fph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/fit_policy_hole_allocator.sv
// Fit-policy hole allocator: hole table in one RAM, sequential search per request.
// Load: goes from accept through S_DONE to the result beat. Request: reads one RAM entry per
// entry searched, then writes back the chosen hole in S_WRITE when one fits.
// One item in flight; the next is accepted once the result sits in the output register.
// Synchronous reset clears the valid bits of all entries (they read as zero), sets
// policy to first fit and holes_in_use to 10. Depends on fph_pkg and fph_ram.
module fit_policy_hole_allocator #(
  parameter int MAX_HOLES = fph_pkg::MAX_HOLES_DEF,
  parameter int ADDR_BITS = fph_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fph_pkg::CFG_DATA_W-1:0]  cfg_data,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fph_pkg::OPCODE_W-1:0]    opcode,
  input  logic [fph_pkg::SLOT_W-1:0]      slot,
  input  logic [fph_pkg::FIELD_W-1:0]     hole_start,
  input  logic [fph_pkg::FIELD_W-1:0]     hole_end,
  input  logic [fph_pkg::FIELD_W-1:0]     request_size,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fph_pkg::STATUS_W-1:0]    status,
  output logic [fph_pkg::FIELD_W-1:0]     granted_start,
  output logic [fph_pkg::SLOT_W-1:0]      granted_slot,
  output logic [fph_pkg::FIELD_W-1:0]     size_before
);

  import fph_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int DW    = 2 * AW;
  localparam int IW    = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam int CW    = (AW > FIELD_W) ? AW : FIELD_W;
  localparam int PW    = (IW > SLOT_W) ? IW : SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state;
  logic [POLICY_W-1:0]  policy;
  logic [HOLES_W-1:0]   holes_in_use;
  logic [MAX_HOLES-1:0] vld;

  // request context
  logic [FIELD_W-1:0]   req_size;
  logic [CNT_W-1:0]     scan_n;
  logic [CNT_W-1:0]     iss;
  logic                 ev_vld;
  logic                 ev_ok;
  logic [IW-1:0]        ev_idx;
  logic                 found;
  logic [AW-1:0]        best;
  logic [IW-1:0]        pick;
  logic [AW-1:0]        pick_start;
  logic [AW-1:0]        pick_end;

  // pending result
  status_t              res_status;
  logic [FIELD_W-1:0]   res_start;
  logic [SLOT_W-1:0]    res_slot;
  logic [FIELD_W-1:0]   res_size;

  // RAM ports
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [DW-1:0]        ram_rdata;

  // load decode
  logic [AW-1:0]        ld_start;
  logic [AW-1:0]        ld_end;
  logic                 ld_bad;
  logic                 in_acc;

  // scan datapath
  logic                 first_fit;
  logic                 issue;
  logic [DW-1:0]        ev_data;
  logic [AW-1:0]        ev_start;
  logic [AW-1:0]        ev_end;
  logic [AW-1:0]        ev_size;
  logic                 ev_fits;
  logic                 take;
  logic                 scan_done;
  logic                 scan_fail;
  logic [CNT_W-1:0]     sat_n;

  // width adapters toward the fixed-width result fields
  logic [CW-1:0]        start_w;
  logic [CW-1:0]        best_w;
  logic [PW-1:0]        pick_w;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign ld_start = AW'(hole_start);
  assign ld_end   = AW'(hole_end);
  assign ld_bad   = (ld_end < ld_start) || (32'(slot) >= 32'(MAX_HOLES));

  assign sat_n = (32'(holes_in_use) > 32'(MAX_HOLES)) ? CNT_W'(MAX_HOLES)
                                                       : CNT_W'(holes_in_use);

  assign first_fit = (policy != POL_BEST) && (policy != POL_WORST);
  assign issue     = (state == S_SCAN) && (iss != scan_n) && !(first_fit && found);

  // entries never written read as an empty hole at address zero
  assign ev_data  = ev_ok ? ram_rdata : '0;
  assign ev_start = ev_data[DW-1:AW];
  assign ev_end   = ev_data[AW-1:0];
  assign ev_size  = ev_end - ev_start;
  assign ev_fits  = CW'(ev_size) >= CW'(req_size);

  always_comb begin
    take = 1'b0;
    if (ev_vld && ev_fits) begin
      unique case (policy)
        POL_BEST:  take = !found || (ev_size < best);
        POL_WORST: take = !found || (ev_size > best);
        default:   take = !found;
      endcase
    end
  end

  assign scan_done = (state == S_SCAN) && !issue && !ev_vld;
  assign scan_fail = !found || ((policy == POL_WORST) && (best == '0));

  assign start_w = CW'(pick_start);
  assign best_w  = CW'(best);
  assign pick_w  = PW'(pick);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = {pick_start + AW'(req_size), pick_end};
    if (state == S_WRITE) begin
      ram_we = 1'b1;
    end else if (in_acc && (opcode == OP_LOAD) && !ld_bad) begin
      ram_we    = 1'b1;
      ram_waddr = IW'(slot);
      ram_wdata = {ld_start, ld_end};
    end
  end

  assign ram_re = issue;

  fph_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_HOLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss[IW-1:0]),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_FIRST;
      holes_in_use <= HOLES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:       policy       <= cfg_data[POLICY_W-1:0];
        REG_HOLES_IN_USE: holes_in_use <= cfg_data[HOLES_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      ev_vld    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      ev_vld <= issue;

      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode == OP_LOAD) begin
              state <= S_DONE;
            end else begin
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            found <= 1'b1;
          end
          if (scan_done) begin
            state <= scan_fail ? S_DONE : S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      iss    <= iss + CNT_W'(1);
      ev_idx <= iss[IW-1:0];
      ev_ok  <= vld[iss[IW-1:0]];
    end
    if (take) begin
      best       <= ev_size;
      pick       <= ev_idx;
      pick_start <= ev_start;
      pick_end   <= ev_end;
    end

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          req_size   <= request_size;
          scan_n     <= sat_n;
          iss        <= '0;
          res_status <= ld_bad ? ST_BAD_LOAD : ST_LOADED;
          res_start  <= '0;
          res_slot   <= '0;
          res_size   <= '0;
        end
      end
      S_SCAN: begin
        if (scan_done && scan_fail) begin
          res_status <= ST_NO_FIT;
        end
      end
      S_WRITE: begin
        res_status <= ST_ALLOC;
        res_start  <= start_w[FIELD_W-1:0];
        res_slot   <= pick_w[SLOT_W-1:0];
        res_size   <= best_w[FIELD_W-1:0];
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          status        <= res_status;
          granted_start <= res_start;
          granted_slot  <= res_slot;
          size_before   <= res_size;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/fph_checker.sv
// Port-level checks for the fit-policy hole allocator, bound to the top level.
// Depends on fph_pkg.
module fph_checker #(
  parameter int MAX_HOLES = fph_pkg::MAX_HOLES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fph_pkg::STATUS_W-1:0]   status,
  input logic [fph_pkg::FIELD_W-1:0]    granted_start,
  input logic [fph_pkg::SLOT_W-1:0]     granted_slot,
  input logic [fph_pkg::FIELD_W-1:0]    size_before
);

  import fph_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_start)
      && $stable(granted_slot) && $stable(size_before))
    else $error("result beat changed while stalled");

  // grant fields are only populated on an allocation
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ALLOC) |->
      (granted_start == '0) && (granted_slot == '0) && (size_before == '0))
    else $error("grant fields set on a non-allocation result");

  // a granted slot lies inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ALLOC) |-> (32'(granted_slot) < 32'(MAX_HOLES)))
    else $error("granted slot beyond table");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

endmodule

bind fit_policy_hole_allocator fph_checker #(
  .MAX_HOLES (MAX_HOLES)
) u_fph_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .granted_start (granted_start),
  .granted_slot  (granted_slot),
  .size_before   (size_before)
);

FILE: sim/tb_fit_policy_hole_allocator.sv
// Self-checking testbench for fit_policy_hole_allocator: directed and random load/request beats
// checked against an in-bench allocation predictor. Depends on fph_pkg and the allocator RTL.
module tb_fit_policy_hole_allocator;
  import fph_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int NUM_SLOTS   = MAX_HOLES_DEF;
  localparam int BLOCK_ITEMS = 140;
  localparam cfg_reg_t REG_UNMAPPED = cfg_reg_t'(2'd3);

  typedef struct packed {
    status_t                 status;
    logic [FIELD_W-1:0]      granted_start;
    logic [SLOT_W-1:0]       granted_slot;
    logic [FIELD_W-1:0]      size_before;
  } alloc_result_t;

  class hole_alloc_scoreboard;
    logic [FIELD_W-1:0] hole_base[NUM_SLOTS];
    logic [FIELD_W-1:0] hole_limit[NUM_SLOTS];
    policy_t            policy;
    logic [HOLES_W-1:0] holes_in_use;
    alloc_result_t      expected_results[$];
    int                 errors;

    function new();
      foreach (hole_base[i]) begin
        hole_base[i]  = '0;
        hole_limit[i] = '0;
      end
      policy       = POL_FIRST;
      holes_in_use = HOLES_IN_USE_RST;
      errors       = 0;
    endfunction

    function int searched_slots();
      return (holes_in_use > NUM_SLOTS) ? NUM_SLOTS : int'(holes_in_use);
    endfunction

    function logic [FIELD_W-1:0] hole_size(int i);
      return hole_limit[i] - hole_base[i];
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_POLICY:       policy = policy_t'(data[POLICY_W-1:0]);
        REG_HOLES_IN_USE: holes_in_use = data;
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted beat and update the hole table.
    function void note_item(opcode_t op, logic [SLOT_W-1:0] s, logic [FIELD_W-1:0] lo,
                            logic [FIELD_W-1:0] hi, logic [FIELD_W-1:0] req);
      alloc_result_t      r;
      bit                 found;
      bit                 stop;
      int                 pick;
      logic [FIELD_W-1:0] best;
      logic [FIELD_W-1:0] sz;
      r     = '0;
      found = 1'b0;
      stop  = 1'b0;
      pick  = 0;
      best  = '0;
      if (op == OP_LOAD) begin
        if (hi < lo) begin
          r.status = ST_BAD_LOAD;
        end else begin
          hole_base[s]  = lo;
          hole_limit[s] = hi;
          r.status      = ST_LOADED;
        end
      end else begin
        for (int i = 0; i < searched_slots() && !stop; i++) begin
          sz = hole_size(i);
          if (sz >= req) begin
            case (policy)
              POL_BEST: begin
                if (!found || sz < best) begin
                  found = 1'b1;
                  best  = sz;
                  pick  = i;
                end
              end
              POL_WORST: begin
                if (!found || sz > best) begin
                  found = 1'b1;
                  best  = sz;
                  pick  = i;
                end
              end
              default: begin
                found = 1'b1;
                best  = sz;
                pick  = i;
                stop  = 1'b1;
              end
            endcase
          end
        end
        // worst fit refuses a largest hole of size zero
        if (found && policy == POL_WORST && best == 0) found = 1'b0;
        if (!found) begin
          r.status = ST_NO_FIT;
        end else begin
          r.status        = ST_ALLOC;
          r.granted_start = hole_base[pick];
          r.granted_slot  = SLOT_W'(pick);
          r.size_before   = best;
          hole_base[pick] = hole_base[pick] + req;
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [FIELD_W-1:0] gstart,
                               logic [SLOT_W-1:0] gslot, logic [FIELD_W-1:0] gsize);
      alloc_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation pending: status %0d", st);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        errors++;
      end
      if (gstart !== exp_r.granted_start) begin
        $error("granted_start: expected %0h, got %0h", exp_r.granted_start, gstart);
        errors++;
      end
      if (gslot !== exp_r.granted_slot) begin
        $error("granted_slot: expected %0d, got %0d", exp_r.granted_slot, gslot);
        errors++;
      end
      if (gsize !== exp_r.size_before) begin
        $error("size_before: expected %0h, got %0h", exp_r.size_before, gsize);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [SLOT_W-1:0]     slot;
  logic [FIELD_W-1:0]    hole_start;
  logic [FIELD_W-1:0]    hole_end;
  logic [FIELD_W-1:0]    request_size;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   status;
  logic [FIELD_W-1:0]    granted_start;
  logic [SLOT_W-1:0]     granted_slot;
  logic [FIELD_W-1:0]    size_before;

  hole_alloc_scoreboard alloc_sb;
  int sender_idle_pct;
  int receiver_idle_pct;
  int stall_cycles;

  fit_policy_hole_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .slot         (slot),
    .hole_start   (hole_start),
    .hole_end     (hole_end),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_start(granted_start),
    .granted_slot (granted_slot),
    .size_before  (size_before)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random, check every accepted result beat.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      alloc_sb.check_result(status, granted_start, granted_slot, size_before);
  end

  // Abort when no channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(opcode_t op, logic [SLOT_W-1:0] s, logic [FIELD_W-1:0] lo,
                           logic [FIELD_W-1:0] hi, logic [FIELD_W-1:0] req);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    slot         <= s;
    hole_start   <= lo;
    hole_end     <= hi;
    request_size <= req;
    do @(posedge clk); while (!in_ready);
    alloc_sb.note_item(op, s, lo, hi, req);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alloc_sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    alloc_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed loads into searched slots and requests sized to fit, plus noise.
  task automatic run_random_items(int count);
    int                 active;
    int                 roll;
    int                 pick;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] req;
    for (int k = 0; k < count; k++) begin
      active = alloc_sb.searched_slots();
      roll   = $urandom_range(99);
      pick   = (active > 0 && $urandom_range(3) != 0) ? $urandom_range(active - 1)
                                                       : $urandom_range(NUM_SLOTS - 1);
      lo     = FIELD_W'($urandom);
      if (roll < 30) begin
        hi = lo + (($urandom_range(1) == 0) ? FIELD_W'($urandom_range(255))
                                            : FIELD_W'($urandom_range(16'hFFFF - lo)));
        send_item(OP_LOAD, SLOT_W'(pick), lo, hi, FIELD_W'($urandom));
      end else if (roll < 36) begin
        send_item(OP_LOAD, SLOT_W'($urandom), lo, FIELD_W'($urandom), FIELD_W'($urandom));
      end else begin
        roll = $urandom_range(99);
        if (roll < 40)
          req = FIELD_W'($urandom_range(300));
        else if (roll < 70)
          req = alloc_sb.hole_size(pick) + FIELD_W'($urandom_range(2)) - 1'b1;
        else if (roll < 85)
          req = '0;
        else
          req = FIELD_W'($urandom);
        send_item(OP_ALLOC, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), req);
      end
    end
  endtask

  int policy_seq[9] = '{1, 2, 3, 0, 30, 2, 29, 2, 0};
  int holes_seq[9]  = '{16, 16, 5, 31, 1, 0, 17, 8, 12};

  initial begin
    rst               = 1'b1;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    opcode            = '0;
    slot              = '0;
    hole_start        = '0;
    hole_end          = '0;
    request_size      = '0;
    stall_cycles      = 0;
    sender_idle_pct   = 9;
    receiver_idle_pct = 82;
    alloc_sb          = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, bad load, each policy, zero and saturated hole counts.
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_LOAD, 4'd0, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(OP_LOAD, 4'd1, 16'd5, 16'd4, 16'h0000);
    send_item(OP_LOAD, 4'd1, 16'd100, 16'd300, 16'h0000);
    send_item(OP_LOAD, 4'd2, 16'd1000, 16'd1100, 16'h0000);
    send_item(OP_LOAD, 4'd3, 16'd50, 16'd50, 16'h0000);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd100);
    wait_results_drained();
    write_cfg(REG_POLICY, CFG_DATA_W'(POL_BEST));
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd50);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd0);
    wait_results_drained();
    write_cfg(REG_POLICY, CFG_DATA_W'(POL_WORST));
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd1);
    wait_results_drained();
    write_cfg(REG_HOLES_IN_USE, 5'd1);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd0);
    wait_results_drained();
    write_cfg(REG_HOLES_IN_USE, 5'd0);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd0);
    wait_results_drained();
    write_cfg(REG_POLICY, CFG_DATA_W'(POL_UNUSED));
    write_cfg(REG_HOLES_IN_USE, 5'd31);
    send_item(OP_LOAD, 4'd15, 16'd10, 16'd20, 16'h0000);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'd10);
    send_item(OP_ALLOC, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);

    // Random blocks: three per idling mode, each under its own register setting.
    for (int b = 0; b < 9; b++) begin
      wait_results_drained();
      case (b / 3)
        0: begin
          sender_idle_pct   = 9;
          receiver_idle_pct = 82;
        end
        1: begin
          sender_idle_pct   = 82;
          receiver_idle_pct = 9;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      if (b == 4) write_cfg(REG_UNMAPPED, CFG_DATA_W'($urandom));
      write_cfg(REG_POLICY, CFG_DATA_W'(policy_seq[b]));
      write_cfg(REG_HOLES_IN_USE, CFG_DATA_W'(holes_seq[b]));
      run_random_items(BLOCK_ITEMS);
    end

    wait_results_drained();
    repeat (30) @(posedge clk);
    if (alloc_sb.expected_results.size() != 0) begin
      $error("%0d expected results never arrived", alloc_sb.expected_results.size());
      alloc_sb.errors++;
    end
    if (alloc_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
